>>> design/mbg_pkg.sv
// Package for the maze backtracker generator.
// Holds the transaction structs, tile kinds, direction codes and defaults.
// No dependencies.
package mbg_pkg;

   localparam int MAX_DIM_DEFAULT     = 64;
   localparam int STACK_DEPTH_DEFAULT = 1024;

   localparam logic [5:0]  GRID_RESET = 6'd31;
   localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;

   localparam logic [1:0] KIND_BORDER = 2'd0;
   localparam logic [1:0] KIND_WALL   = 2'd1;
   localparam logic [1:0] KIND_WALK   = 2'd2;

   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic CMD_GENERATE = 1'b0;
   localparam logic CMD_READ     = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] seed;
      logic [5:0]  tile_x;
      logic [5:0]  tile_y;
   } req_type;

   typedef struct packed {
      logic [1:0] tile_kind;
      logic       generation_done;
      logic       out_of_range;
   } rsp_type;

endpackage

>>> design/maze_backtracker_generator.sv
// Maze generator with tile read port (top level).
// A read passes through states S_RD and S_RD_WT, and its response strobe is registered.
// A generate clears all 2**(2*clog2(MAX_DIM)) tile entries, runs an init step, then carves
// and backtracks, and at last writes each tile of the room box.
// One transaction at a time; busy falls as the response strobe rises.
// Reset is synchronous: grid 31x31, no maze (reads give wall), LFSR at one; no stall.
module maze_backtracker_generator #(
   parameter int MAX_DIM     = mbg_pkg::MAX_DIM_DEFAULT,
   parameter int STACK_DEPTH = mbg_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mbg_pkg::req_type req_data,
   output logic             rsp_valid,
   output mbg_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [5:0]       csr_wdata
);

   localparam int CW  = $clog2(MAX_DIM);
   localparam int AW  = 2 * CW;
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int LIM = (MAX_DIM % 2 == 0) ? MAX_DIM - 1 : MAX_DIM;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_RD       = 13'b0000000000010,
      S_RD_WT    = 13'b0000000000100,
      S_CLEAR    = 13'b0000000001000,
      S_INIT     = 13'b0000000010000,
      S_TOP_RD   = 13'b0000000100000,
      S_TOP_WT   = 13'b0000001000000,
      S_NBR      = 13'b0000010000000,
      S_DECIDE   = 13'b0000100000000,
      S_PICK     = 13'b0001000000000,
      S_CARVE1   = 13'b0010000000000,
      S_CARVE2   = 13'b0100000000000,
      S_ROOM     = 13'b1000000000000
   } state_type;

   function automatic logic [CW-1:0] eff_dim(input logic [5:0] v);
      int d;
      begin
         d = int'(v) | 1;
         if (d < 3) d = 3;
         if (d > LIM) d = LIM;
         return CW'(d);
      end
   endfunction

   function automatic logic [CW:0] step_x(input logic [CW-1:0] x, input logic [1:0] d,
                                          input logic [CW:0] span);
      case (d)
         mbg_pkg::DIR_LEFT:  return {1'b0, x} - span;
         mbg_pkg::DIR_RIGHT: return {1'b0, x} + span;
         default:            return {1'b0, x};
      endcase
   endfunction

   function automatic logic [CW:0] step_y(input logic [CW-1:0] y, input logic [1:0] d,
                                          input logic [CW:0] span);
      case (d)
         mbg_pkg::DIR_UP:   return {1'b0, y} - span;
         mbg_pkg::DIR_DOWN: return {1'b0, y} + span;
         default:           return {1'b0, y};
      endcase
   endfunction

   state_type        state_ff, state_in;
   mbg_pkg::req_type req_ff, req_in;
   logic [5:0]       gw_ff, gw_in, gh_ff, gh_in;
   logic [CW-1:0]    w_ff, w_in, h_ff, h_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [3:0]       mask_ff, mask_in;
   logic [1:0]       dir_ff, dir_in;
   logic [31:0]      lfsr_ff, lfsr_in;
   logic [SPW-1:0]   sp_ff, sp_in;
   logic             valid_ff, valid_in;
   logic [CW-1:0]    rx_ff, rx_in, ry_ff, ry_in, sx_ff, sx_in, ex_ff, ex_in, ey_ff, ey_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mbg_pkg::rsp_type rsp_ff, rsp_in;

   logic [1:0]    tile_mem [2**AW];
   logic          tile_we;
   logic [AW-1:0] tile_waddr, tile_raddr;
   logic [1:0]    tile_wdata, tile_rdata_ff;

   logic [AW-1:0]  stk_mem [STACK_DEPTH];
   logic           stk_we;
   logic [SAW-1:0] stk_waddr, stk_raddr;
   logic [AW-1:0]  stk_wdata, stk_rdata_ff;

   logic [1:0]    pick_dir;
   logic [CW-1:0] cur_w, cur_h, rd_x, rd_y, clr_x, clr_y, rw, rh;
   logic [CW+7:0] rw_prod, rh_prod;
   logic [CW:0]   nx, ny, ex_x, ex_y, mx, my;
   logic [1:0]    iss_dir, ev_dir;
   logic          ev_inb, rd_oor;

   mbg_pick u_pick (
      .cand_mask(mask_ff),
      .lfsr     (lfsr_ff),
      .dir      (pick_dir)
   );

   always_ff @(posedge clock) begin
      if (tile_we) begin
         tile_mem[tile_waddr] <= tile_wdata;
      end
      tile_rdata_ff <= tile_mem[tile_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   assign cur_w   = eff_dim(gw_ff);
   assign cur_h   = eff_dim(gh_ff);
   assign rd_x    = CW'(req_ff.tile_x);
   assign rd_y    = CW'(req_ff.tile_y);
   assign rd_oor  = (9'(req_ff.tile_x) >= 9'(cur_w)) || (9'(req_ff.tile_y) >= 9'(cur_h));
   assign clr_x   = clr_ff[CW-1:0];
   assign clr_y   = clr_ff[AW-1:CW];
   // Division by three as a multiply by 171/512, exact for values below 512.
   assign rw_prod = (CW+8)'(w_ff) * (CW+8)'(171);
   assign rh_prod = (CW+8)'(h_ff) * (CW+8)'(171);
   assign rw      = CW'(rw_prod >> 9);
   assign rh      = CW'(rh_prod >> 9);
   assign iss_dir = cnt_ff[1:0];
   assign ev_dir  = 2'(cnt_ff - 3'd1);
   assign nx      = step_x(cx_ff, iss_dir, (CW+1)'(2));
   assign ny      = step_y(cy_ff, iss_dir, (CW+1)'(2));
   assign ex_x    = step_x(cx_ff, ev_dir, (CW+1)'(2));
   assign ex_y    = step_y(cy_ff, ev_dir, (CW+1)'(2));
   assign ev_inb  = (ex_x != '0) && (ex_x < {1'b0, w_ff} - (CW+1)'(1)) &&
                    (ex_y != '0) && (ex_y < {1'b0, h_ff} - (CW+1)'(1));
   assign mx      = step_x(cx_ff, dir_ff, (CW+1)'(1));
   assign my      = step_y(cy_ff, dir_ff, (CW+1)'(1));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      gw_in        = gw_ff;
      gh_in        = gh_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      clr_in       = clr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      dir_in       = dir_ff;
      lfsr_in      = lfsr_ff;
      sp_in        = sp_ff;
      valid_in     = valid_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      sx_in        = sx_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tile_we      = 1'b0;
      tile_waddr   = {rd_y, rd_x};
      tile_wdata   = mbg_pkg::KIND_WALK;
      tile_raddr   = {rd_y, rd_x};
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[SAW-1:0];
      stk_wdata    = {cy_ff, cx_ff};
      stk_raddr    = SAW'(sp_ff - SPW'(1));

      if (csr_we) begin
         case (csr_index)
            mbg_pkg::CSR_WIDTH:  gw_in = csr_wdata;
            mbg_pkg::CSR_HEIGHT: gh_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.command == mbg_pkg::CMD_READ) begin
                  state_in = S_RD;
               end else begin
                  w_in     = cur_w;
                  h_in     = cur_h;
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_RD: begin
            state_in = S_RD_WT;
         end
         S_RD_WT: begin
            rsp_valid_in           = 1'b1;
            rsp_in.generation_done = 1'b0;
            rsp_in.out_of_range    = rd_oor;
            if (rd_oor) begin
               rsp_in.tile_kind = mbg_pkg::KIND_BORDER;
            end else if (valid_ff) begin
               rsp_in.tile_kind = tile_rdata_ff;
            end else begin
               rsp_in.tile_kind = mbg_pkg::KIND_WALL;
            end
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            tile_we    = 1'b1;
            tile_waddr = clr_ff;
            if (clr_x != '0 && clr_x < w_ff - CW'(1) && clr_y != '0 && clr_y < h_ff - CW'(1))
            begin
               tile_wdata = mbg_pkg::KIND_WALL;
            end else begin
               tile_wdata = mbg_pkg::KIND_BORDER;
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            tile_we    = 1'b1;
            tile_waddr = {CW'(1), CW'(1)};
            stk_we     = 1'b1;
            stk_waddr  = '0;
            stk_wdata  = {CW'(1), CW'(1)};
            sp_in      = SPW'(1);
            lfsr_in    = (req_ff.seed == '0) ? 32'd1 : req_ff.seed;
            cx_in      = CW'(1);
            cy_in      = CW'(1);
            cnt_in     = '0;
            state_in   = S_NBR;
         end
         S_TOP_RD: begin
            state_in = S_TOP_WT;
         end
         S_TOP_WT: begin
            cx_in    = stk_rdata_ff[CW-1:0];
            cy_in    = stk_rdata_ff[AW-1:CW];
            cnt_in   = '0;
            state_in = S_NBR;
         end
         S_NBR: begin
            // Issue the read for one neighbor while checking the previous one.
            tile_raddr = {ny[CW-1:0], nx[CW-1:0]};
            if (cnt_ff == 3'd0) begin
               mask_in = '0;
            end else begin
               mask_in[ev_dir] = ev_inb && (tile_rdata_ff == mbg_pkg::KIND_WALL);
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (mask_ff != '0) begin
               lfsr_in  = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? mbg_pkg::LFSR_TAPS : 32'd0);
               state_in = S_PICK;
            end else begin
               sp_in = sp_ff - SPW'(1);
               if (sp_ff == SPW'(1)) begin
                  sx_in    = CW'((w_ff - rw) >> 1);
                  ex_in    = CW'((w_ff - rw) >> 1) + rw - CW'(1);
                  ey_in    = CW'((h_ff - rh) >> 1) + rh - CW'(1);
                  rx_in    = CW'((w_ff - rw) >> 1);
                  ry_in    = CW'((h_ff - rh) >> 1);
                  state_in = S_ROOM;
               end else begin
                  state_in = S_TOP_RD;
               end
            end
         end
         S_PICK: begin
            dir_in   = pick_dir;
            state_in = S_CARVE1;
         end
         S_CARVE1: begin
            tile_we    = 1'b1;
            tile_waddr = {CW'(step_y(cy_ff, dir_ff, (CW+1)'(2))),
                          CW'(step_x(cx_ff, dir_ff, (CW+1)'(2)))};
            state_in   = S_CARVE2;
         end
         S_CARVE2: begin
            tile_we    = 1'b1;
            tile_waddr = {my[CW-1:0], mx[CW-1:0]};
            // A full stack keeps the walk at the current top.
            if (sp_ff < SPW'(STACK_DEPTH)) begin
               stk_we    = 1'b1;
               stk_wdata = {CW'(step_y(cy_ff, dir_ff, (CW+1)'(2))),
                            CW'(step_x(cx_ff, dir_ff, (CW+1)'(2)))};
               sp_in     = sp_ff + SPW'(1);
               cx_in     = CW'(step_x(cx_ff, dir_ff, (CW+1)'(2)));
               cy_in     = CW'(step_y(cy_ff, dir_ff, (CW+1)'(2)));
            end
            cnt_in   = '0;
            state_in = S_NBR;
         end
         S_ROOM: begin
            tile_waddr = {ry_ff, rx_ff};
            tile_we    = (rx_ff != '0) && (rx_ff < w_ff - CW'(1)) &&
                         (ry_ff != '0) && (ry_ff < h_ff - CW'(1));
            if (rx_ff == ex_ff) begin
               rx_in = sx_ff;
               ry_in = ry_ff + CW'(1);
               if (ry_ff == ey_ff) begin
                  valid_in               = 1'b1;
                  rsp_valid_in           = 1'b1;
                  rsp_in.tile_kind       = mbg_pkg::KIND_BORDER;
                  rsp_in.generation_done = 1'b1;
                  rsp_in.out_of_range    = 1'b0;
                  state_in               = S_IDLE;
               end
            end else begin
               rx_in = rx_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gw_ff        <= mbg_pkg::GRID_RESET;
         gh_ff        <= mbg_pkg::GRID_RESET;
         sp_ff        <= '0;
         lfsr_ff      <= 32'd1;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         sp_ff        <= sp_in;
         lfsr_ff      <= lfsr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      w_ff    <= w_in;
      h_ff    <= h_in;
      clr_ff  <= clr_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cnt_ff  <= cnt_in;
      mask_ff <= mask_in;
      dir_ff  <= dir_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      sx_ff   <= sx_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/mbg_pick.sv
// Direction picker: reduces the LFSR value modulo the candidate count and
// selects that candidate from the four-bit candidate mask.
// Depends on mbg_pkg.
module mbg_pick (
   input  logic [3:0]  cand_mask,
   input  logic [31:0] lfsr,
   output logic [1:0]  dir
);

   logic [2:0] count;
   logic [9:0] s1;
   logic [8:0] s2;
   logic [4:0] s3;
   logic [2:0] s4;
   logic [1:0] mod3;
   logic [1:0] rank;
   logic [2:0] seen;

   // Powers of four are one modulo three, so digit sums keep the residue.
   always_comb begin
      count = 3'(cand_mask[0]) + 3'(cand_mask[1]) + 3'(cand_mask[2]) + 3'(cand_mask[3]);
      s1 = 10'(lfsr[7:0]) + 10'(lfsr[15:8]) + 10'(lfsr[23:16]) + 10'(lfsr[31:24]);
      s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
      s3 = 5'(s2[3:0]) + 5'(s2[7:4]) + 5'(s2[8]);
      s4 = 3'(s3[1:0]) + 3'(s3[3:2]) + 3'(s3[4]);
      if (s4 >= 3'd6) begin
         mod3 = 2'(s4 - 3'd6);
      end else if (s4 >= 3'd3) begin
         mod3 = 2'(s4 - 3'd3);
      end else begin
         mod3 = s4[1:0];
      end
      case (count)
         3'd2:    rank = {1'b0, lfsr[0]};
         3'd3:    rank = mod3;
         3'd4:    rank = lfsr[1:0];
         default: rank = 2'd0;
      endcase
      dir  = mbg_pkg::DIR_UP;
      seen = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_mask[i]) begin
            if (seen == {1'b0, rank}) begin
               dir = 2'(i);
            end
            seen = seen + 3'd1;
         end
      end
   end

endmodule

>>> design/mbg_checker.sv
// Port-level checker for the maze backtracker generator, bound to the top.
// Depends on mbg_pkg and maze_backtracker_generator.
module mbg_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mbg_pkg::rsp_type rsp_data,
   input logic             rsp_valid
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("transaction finished without a response");

   a_gen_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.generation_done) |->
         (rsp_data.tile_kind == mbg_pkg::KIND_BORDER && !rsp_data.out_of_range))
      else $error("generate acknowledge carries tile data");

   a_oor_border: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.tile_kind == mbg_pkg::KIND_BORDER))
      else $error("out-of-range read did not return border");

endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_data (rsp_data),
   .rsp_valid(rsp_valid)
);
